FILE: rtl/stepper_trapezoid_profile_unit_defines.svh
// Assertion macros shared by the stepper profile RTL.
// Included by the modules that check their own control logic.
`ifndef STEPPER_TRAPEZOID_PROFILE_UNIT_DEFINES_SVH
`define STEPPER_TRAPEZOID_PROFILE_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Check a property on every rising edge, ignored while reset is active.
`define STP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Check a property on every rising edge, reset included.
`define STP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STP_ASSERT(lbl, clk, rst_n, prop, msg)
`define STP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

FILE: rtl/stp_pkg.sv
// Shared types and constants for the stepper trapezoid profile unit.
// No dependencies.
package stp_pkg;
    localparam int POS_W   = 32;
    localparam int SPD_W   = 16;
    localparam int TICK_W  = 20;
    localparam int ACC_W   = 16;
    localparam int CFG_W   = 16;
    localparam int CFGI_W  = 3;

    localparam logic [TICK_W-1:0] TICKS_PER_SECOND   = 20'd1000000;
    localparam logic [ACC_W-1:0]  ACCEL_PERIOD_TICKS = 16'd50000;
    localparam logic [TICK_W-1:0] STEP_CNT_MAX       = 20'hFFFFF;
    localparam logic [ACC_W-1:0]  ACC_CNT_MAX        = 16'hFFFF;
    localparam logic [SPD_W-1:0]  SPEED_MAX          = 16'hFFFF;

    typedef enum logic [1:0] {
        FUNC_TICK   = 2'd0,
        FUNC_GOTO   = 2'd1,
        FUNC_STOP   = 2'd2,
        FUNC_SETPOS = 2'd3
    } t_func;

    localparam logic [CFGI_W-1:0] CFG_SMOOTH  = 3'd0;
    localparam logic [CFGI_W-1:0] CFG_ACCEL   = 3'd1;
    localparam logic [CFGI_W-1:0] CFG_REQ_SPD = 3'd2;
    localparam logic [CFGI_W-1:0] CFG_SPD_LIM = 3'd3;
    localparam logic [CFGI_W-1:0] CFG_REVERSE = 3'd4;
    localparam logic [CFGI_W-1:0] CFG_HOLD    = 3'd5;
endpackage

FILE: rtl/stp_div.sv
// Bit-serial restoring divider: TICKS_PER_SECOND / (speed + 1).
// Depends on stp_pkg. One quotient bit per cycle, TICK_W quotient bits per divide.
module stp_div (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic [stp_pkg::SPD_W-1:0] i_speed,
    output logic                     o_done,
    output logic [stp_pkg::TICK_W-1:0] o_quot
);
    import stp_pkg::*;

    localparam int CNT_W = $clog2(TICK_W + 1);

    logic               r_run;
    logic [CNT_W-1:0]   r_cnt;
    logic [TICK_W-1:0]  r_num;
    logic [TICK_W-1:0]  r_quot;
    logic [SPD_W:0]     r_den;
    logic [SPD_W:0]     r_rem;
    logic               r_done;
    logic [SPD_W+1:0]   w_trial;
    logic               w_ge;

    assign w_trial = {r_rem, r_num[TICK_W-1]};
    assign w_ge    = (w_trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run  <= 1'b1;
                r_cnt  <= CNT_W'(TICK_W);
                r_num  <= TICKS_PER_SECOND;
                r_den  <= {1'b0, i_speed} + 1'b1;
                r_rem  <= '0;
                r_quot <= '0;
            end else if (r_run) begin
                // shift in one dividend bit, subtract when it fits
                r_rem  <= w_ge ? (SPD_W+1)'(w_trial - {1'b0, r_den})
                               : w_trial[SPD_W:0];
                r_quot <= {r_quot[TICK_W-2:0], w_ge};
                r_num  <= {r_num[TICK_W-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == CNT_W'(1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule

FILE: rtl/stepper_trapezoid_profile_unit.sv
// Stepper trapezoid profile unit: top level with sequencer and serial divider.
// Depends on stp_pkg, stp_div and stepper_trapezoid_profile_unit_defines.svh.
//
// Each beat on the input channel is a one-microsecond tick or a command
// (go to, stop, set position); each produces exactly one result beat with
// the step pulse, direction, busy flag, coil release, position and speed.
// One item is worked on at a time; the next beat is accepted once the
// sequencer is back in idle. Stop, set position, a go-to to the current
// position and a smooth go-to pass from the execute state to the output
// state. When the acceleration update, the cruise clamp or a per-step go-to
// loads a new speed, the step interval 1000000/(speed+1) is recomputed by a
// bit-serial divider that holds the sequencer until done (a start, 20
// quotient bits, a done strobe); stop, move end and smooth go-to load
// 1000000 directly. A per-step go-to needs one divide; a tick needs none,
// one (after the acceleration update or after the cruise clamp) or two.
// The midpoint and braking thresholds are registered every cycle from
// goal, start and ramp distance, which settle before the next tick reads
// them. Finished results wait in an output register, so the next beat can
// be accepted while the previous result is stalled; a stalled result holds
// the sequencer in its output state once the next item is finished.
`include "stepper_trapezoid_profile_unit_defines.svh"
module stepper_trapezoid_profile_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [stp_pkg::CFGI_W-1:0] i_cfg_idx,
    input  logic [stp_pkg::CFG_W-1:0]  i_cfg_data,
    input  logic                       i_valid,
    output logic                       o_stall,
    input  logic [1:0]                 i_func,
    input  logic signed [stp_pkg::POS_W-1:0] i_position_value,
    output logic                       o_valid,
    input  logic                       i_stall,
    output logic                       o_step_pulse,
    output logic                       o_dir_forward,
    output logic                       o_moving,
    output logic                       o_release_coils,
    output logic signed [stp_pkg::POS_W-1:0] o_position_now,
    output logic [stp_pkg::SPD_W-1:0]  o_speed_now
);
    import stp_pkg::*;

    typedef enum logic [2:0] {S_IDLE, S_EXEC, S_DIV, S_STEP, S_OUT} t_state;

    // configuration
    logic             r_smooth, r_reverse, r_hold;
    logic [SPD_W-1:0] r_accel, r_req, r_lim;

    // motion state
    t_state            r_state, r_ret;
    t_func             r_func;
    logic [POS_W-1:0]  r_pv;
    logic [POS_W-1:0]  r_cur, r_goal, r_start, r_ramp;
    logic [SPD_W-1:0]  r_speed;
    logic [TICK_W-1:0] r_se, r_interval;
    logic [ACC_W-1:0]  r_ae;
    logic              r_cruise, r_busy;
    logic              r_pulse, r_fwd, r_rel, r_div_go;

    // result register
    logic              r_o_valid, r_o_pulse, r_o_fwd, r_o_moving, r_o_rel;
    logic [POS_W-1:0]  r_o_pos;
    logic [SPD_W-1:0]  r_o_speed;

    logic              w_div_done;
    logic [TICK_W-1:0] w_quot;

    stp_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_speed (r_speed),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    assign o_stall = (r_state != S_IDLE);

    // saturating tick counters
    logic [TICK_W-1:0] w_se_inc;
    logic [ACC_W-1:0]  w_ae_inc;
    logic              w_acc_due;
    assign w_se_inc  = (r_se < STEP_CNT_MAX) ? r_se + 1'b1 : r_se;
    assign w_ae_inc  = (r_ae < ACC_CNT_MAX) ? r_ae + 1'b1 : r_ae;
    assign w_acc_due = r_busy && r_smooth && (w_ae_inc >= ACCEL_PERIOD_TICKS);

    // acceleration update: midpoint and braking window
    logic signed [32:0] w_d, w_half;
    logic signed [34:0] w_mid, w_cur, w_goal, w_gm, w_gp;
    logic signed [34:0] r_mid, r_gm, r_gp;
    logic               r_mid_fwd;
    logic [SPD_W:0]     w_upsum;
    logic [SPD_W-1:0]   w_up, w_brake, w_new_spd;
    logic               w_set_spd;

    always_comb begin
        w_d     = 33'(signed'(r_goal)) - 33'(signed'(r_start));
        if (w_d == 33'sd1 || w_d == -33'sd1)
            w_half = w_d;
        else if (w_d < 0)
            w_half = (w_d + 33'sd1) >>> 1;
        else
            w_half = w_d >>> 1;
        w_mid   = 35'(signed'(r_start)) + 35'(w_half);
        w_cur   = 35'(signed'(r_cur));
        w_goal  = 35'(signed'(r_goal));
        w_gm    = w_goal - signed'({3'b000, r_ramp});
        w_gp    = w_goal + signed'({3'b000, r_ramp});
        w_upsum = {1'b0, r_speed} + {1'b0, r_accel};
        w_up    = w_upsum[SPD_W] ? SPEED_MAX : w_upsum[SPD_W-1:0];
        w_brake = (r_cur != r_goal && r_speed > r_accel) ? r_speed - r_accel : r_accel;
        w_set_spd = 1'b0;
        w_new_spd = r_speed;
        if (r_mid_fwd) begin
            if (!r_cruise && w_cur < r_mid) begin
                w_set_spd = 1'b1;
                w_new_spd = w_up;
            end else if ((!r_cruise && w_cur > r_mid) || w_cur >= r_gm) begin
                w_set_spd = 1'b1;
                w_new_spd = w_brake;
            end
        end else begin
            if (!r_cruise && w_cur > r_mid) begin
                w_set_spd = 1'b1;
                w_new_spd = w_up;
            end else if ((!r_cruise && w_cur < r_mid) || w_cur <= r_gp) begin
                w_set_spd = 1'b1;
                w_new_spd = w_brake;
            end
        end
    end

    // hold the thresholds in registers to keep the compare path short
    always_ff @(posedge i_clk) begin
        r_mid     <= w_mid;
        r_mid_fwd <= (w_half > 33'sd0);
        r_gm      <= w_gm;
        r_gp      <= w_gp;
    end

    // step phase helpers
    logic             w_dir_up;
    logic [SPD_W-1:0] w_tgt;
    logic [POS_W-1:0] w_next_cur;
    logic signed [32:0] w_dist;
    logic [POS_W-1:0] w_abs;
    assign w_dir_up   = signed'(r_goal) > signed'(r_cur);
    assign w_tgt      = (r_req < r_lim) ? r_req : r_lim;
    assign w_next_cur = w_dir_up ? r_cur + 1'b1 : r_cur - 1'b1;
    assign w_dist     = 33'(signed'(r_start)) - 33'(signed'(w_next_cur));
    assign w_abs      = w_dist[32] ? POS_W'(-w_dist) : w_dist[POS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ret      <= S_OUT;
            r_smooth   <= 1'b0;
            r_accel    <= 16'd1;
            r_req      <= '0;
            r_lim      <= SPEED_MAX;
            r_reverse  <= 1'b0;
            r_hold     <= 1'b0;
            r_cur      <= '0;
            r_goal     <= '0;
            r_start    <= '0;
            r_ramp     <= '0;
            r_speed    <= '0;
            r_se       <= '0;
            r_ae       <= '0;
            r_interval <= TICKS_PER_SECOND;
            r_cruise   <= 1'b0;
            r_busy     <= 1'b0;
            r_div_go   <= 1'b0;
            r_o_valid  <= 1'b0;
        end else begin
            // load a finished result or drop the one just taken
            if (r_state == S_OUT && (!r_o_valid || !i_stall))
                r_o_valid <= 1'b1;
            else if (r_o_valid && !i_stall)
                r_o_valid <= 1'b0;

            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SMOOTH:  r_smooth  <= i_cfg_data[0];
                    CFG_ACCEL:   r_accel   <= i_cfg_data;
                    CFG_REQ_SPD: r_req     <= i_cfg_data;
                    CFG_SPD_LIM: r_lim     <= i_cfg_data;
                    CFG_REVERSE: r_reverse <= i_cfg_data[0];
                    CFG_HOLD:    r_hold    <= i_cfg_data[0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_func  <= t_func'(i_func);
                        r_pv    <= i_position_value;
                        r_pulse <= 1'b0;
                        r_fwd   <= 1'b0;
                        r_rel   <= 1'b0;
                        r_state <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    unique case (r_func)
                        FUNC_TICK: begin
                            r_se <= w_se_inc;
                            r_ae <= w_acc_due ? '0 : w_ae_inc;
                            if (w_acc_due && w_set_spd) begin
                                r_speed  <= w_new_spd;
                                r_div_go <= 1'b1;
                                r_ret    <= S_STEP;
                                r_state  <= S_DIV;
                            end else begin
                                r_state  <= S_STEP;
                            end
                        end
                        FUNC_GOTO: begin
                            r_goal <= r_pv;
                            if (r_cur != r_pv) begin
                                r_start <= r_cur;
                                r_busy  <= 1'b1;
                                if (r_smooth) begin
                                    r_speed    <= '0;
                                    r_interval <= TICKS_PER_SECOND;
                                    r_cruise   <= 1'b0;
                                    r_ramp     <= '0;
                                    r_state    <= S_OUT;
                                end else begin
                                    r_speed  <= w_tgt;
                                    r_div_go <= 1'b1;
                                    r_ret    <= S_OUT;
                                    r_state  <= S_DIV;
                                end
                            end else begin
                                r_state <= S_OUT;
                            end
                        end
                        FUNC_STOP: begin
                            r_rel      <= !r_hold;
                            r_busy     <= 1'b0;
                            r_speed    <= '0;
                            r_interval <= TICKS_PER_SECOND;
                            r_ramp     <= '0;
                            r_state    <= S_OUT;
                        end
                        FUNC_SETPOS: begin
                            r_cur   <= r_pv;
                            r_state <= S_OUT;
                        end
                        default: r_state <= S_OUT;
                    endcase
                end
                S_DIV: begin
                    // hold until the serial divide finishes
                    r_div_go <= 1'b0;
                    if (w_div_done) begin
                        r_interval <= w_quot;
                        r_state    <= r_ret;
                    end
                end
                S_STEP: begin
                    if (r_busy) begin
                        if (r_cur != r_goal) begin
                            if (r_speed != '0 && r_se >= r_interval) begin
                                r_cur   <= w_next_cur;
                                r_pulse <= 1'b1;
                                r_fwd   <= w_dir_up ^ r_reverse;
                                r_se    <= '0;
                                if (r_speed >= w_tgt) begin
                                    if (!r_cruise)
                                        r_ramp <= w_abs;
                                    r_cruise <= 1'b1;
                                    r_speed  <= w_tgt;
                                    r_div_go <= 1'b1;
                                    r_ret    <= S_OUT;
                                    r_state  <= S_DIV;
                                end else begin
                                    r_state  <= S_OUT;
                                end
                            end else begin
                                r_state <= S_OUT;
                            end
                        end else begin
                            // at target: end the move as a stop does
                            r_rel      <= !r_hold;
                            r_busy     <= 1'b0;
                            r_speed    <= '0;
                            r_interval <= TICKS_PER_SECOND;
                            r_ramp     <= '0;
                            r_state    <= S_OUT;
                        end
                    end else begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    // advance only when the result register is free
                    if (!r_o_valid || !i_stall)
                        r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_o_valid || !i_stall)) begin
            r_o_pulse  <= r_pulse;
            r_o_fwd    <= r_fwd;
            r_o_moving <= r_busy;
            r_o_rel    <= r_rel;
            r_o_pos    <= r_cur;
            r_o_speed  <= r_speed;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_step_pulse    = r_o_pulse;
    assign o_dir_forward   = r_o_fwd;
    assign o_moving        = r_o_moving;
    assign o_release_coils = r_o_rel;
    assign o_position_now  = r_o_pos;
    assign o_speed_now     = r_o_speed;

    `STP_ASSERT(a_div_only_in_div, i_clk, i_rst_n, w_div_done |-> r_state == S_DIV, "divider done outside divide state")
    `STP_ASSERT(a_step_while_moving, i_clk, i_rst_n, (o_valid && o_step_pulse) |-> o_moving, "step issued on a finished move")
    `STP_ASSERT(a_release_stops, i_clk, i_rst_n, (o_valid && o_release_coils) |-> !o_moving, "coil release while moving")
    `STP_ASSERT(a_idle_speed_zero, i_clk, i_rst_n, (o_valid && !o_moving) |-> o_speed_now == '0, "nonzero speed while stopped")
endmodule

FILE: tb/stepper_trapezoid_profile_unit_test.sv
// Testbench for the stepper trapezoid profile unit: directed and random beats,
// checked against an in-bench motion predictor. Depends on stp_pkg and the RTL.
`timescale 1ns / 100ps
module stepper_trapezoid_profile_unit_test;
    import stp_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 60;

    typedef struct packed {
        logic              pulse;
        logic              fwd;
        logic              moving;
        logic              rel_coils;
        logic [POS_W-1:0]  pos;
        logic [SPD_W-1:0]  spd;
    } t_motion_beat;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_cfg_we;
    logic [CFGI_W-1:0]   i_cfg_idx;
    logic [CFG_W-1:0]    i_cfg_data;
    logic                i_valid;
    logic                o_stall;
    logic [1:0]          i_func;
    logic signed [POS_W-1:0] i_position_value;
    logic                o_valid;
    logic                i_stall;
    logic                o_step_pulse;
    logic                o_dir_forward;
    logic                o_moving;
    logic                o_release_coils;
    logic signed [POS_W-1:0] o_position_now;
    logic [SPD_W-1:0]    o_speed_now;

    stepper_trapezoid_profile_unit uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_func           (i_func),
        .i_position_value (i_position_value),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_step_pulse     (o_step_pulse),
        .o_dir_forward    (o_dir_forward),
        .o_moving         (o_moving),
        .o_release_coils  (o_release_coils),
        .o_position_now   (o_position_now),
        .o_speed_now      (o_speed_now)
    );

    // Shadow copy of the configuration registers.
    logic              c_smooth, c_rev, c_hold;
    logic [SPD_W-1:0]  c_accel, c_req, c_lim;

    // Shadow copy of the motion state.
    logic [POS_W-1:0]  m_cur, m_goal, m_start, m_ramp;
    logic [SPD_W-1:0]  m_speed;
    logic [TICK_W-1:0] m_step_el, m_interval;
    logic [ACC_W-1:0]  m_acc_el;
    logic              m_cruise, m_busy;

    t_motion_beat      pending_beats[$];
    logic              failed;
    logic              gaps_on;
    logic              stall_on;
    int                rx_hold;
    int                idle_cycles;

    always #5 i_clk = ~i_clk;

    // ---------------------------------------------------------------
    // Motion predictor
    // ---------------------------------------------------------------

    // Load a speed and recompute the step interval from it.
    function automatic void load_speed(logic [SPD_W-1:0] s);
        m_speed    = s;
        m_interval = TICK_W'(32'd1000000 / (32'(s) + 32'd1));
    endfunction

    function automatic void halt_motion();
        m_busy = 1'b0;
        load_speed('0);
        m_ramp = '0;
    endfunction

    function automatic void brake_speed(longint cur, longint goal);
        if (cur != goal && m_speed > c_accel)
            load_speed(m_speed - c_accel);
        else
            load_speed(c_accel);
    endfunction

    // Periodic acceleration update: speed up before the midpoint, brake after
    // it or once inside the recorded ramp distance of the target.
    function automatic void ramp_update();
        longint cur, goal, start, ramp, mid;
        logic [31:0] faster;
        cur    = longint'($signed(m_cur));
        goal   = longint'($signed(m_goal));
        start  = longint'($signed(m_start));
        ramp   = longint'(m_ramp);
        faster = 32'(m_speed) + 32'(c_accel);
        if (faster > 32'hFFFF)
            faster = 32'hFFFF;
        mid = goal - start;
        if (mid == 1 || mid == -1)
            mid = mid * 2;
        mid = mid / 2;
        if (mid > 0) begin
            mid = mid + start;
            if (!m_cruise && cur < mid)
                load_speed(faster[SPD_W-1:0]);
            else if ((!m_cruise && cur > mid) || cur >= goal - ramp)
                brake_speed(cur, goal);
        end else begin
            mid = mid + start;
            if (!m_cruise && cur > mid)
                load_speed(faster[SPD_W-1:0]);
            else if ((!m_cruise && cur < mid) || cur <= goal + ramp)
                brake_speed(cur, goal);
        end
    endfunction

    function automatic t_motion_beat predict_motion(t_func f, logic [POS_W-1:0] pv);
        t_motion_beat r;
        logic         up;
        logic [SPD_W-1:0] tgt;
        longint       d;
        r = '0;
        case (f)
            FUNC_TICK: begin
                if (m_step_el != STEP_CNT_MAX) m_step_el = m_step_el + 1'b1;
                if (m_acc_el != ACC_CNT_MAX)   m_acc_el  = m_acc_el + 1'b1;
                if (m_busy) begin
                    if (c_smooth && m_acc_el >= ACCEL_PERIOD_TICKS) begin
                        ramp_update();
                        m_acc_el = '0;
                    end
                    if (m_cur != m_goal) begin
                        if (m_speed != 0 && m_step_el >= m_interval) begin
                            up    = $signed(m_goal) > $signed(m_cur);
                            tgt   = (c_req < c_lim) ? c_req : c_lim;
                            m_cur = up ? m_cur + 1'b1 : m_cur - 1'b1;
                            r.pulse = 1'b1;
                            r.fwd   = up ^ c_rev;
                            // cruise clamp; remember how far the ramp took
                            if (m_speed >= tgt) begin
                                if (!m_cruise) begin
                                    d = longint'($signed(m_start))
                                        - longint'($signed(m_cur));
                                    m_ramp = POS_W'((d < 0) ? -d : d);
                                end
                                load_speed(tgt);
                                m_cruise = 1'b1;
                            end
                            m_step_el = '0;
                        end
                    end else begin
                        r.rel_coils = !c_hold;
                        halt_motion();
                    end
                end
            end
            FUNC_GOTO: begin
                m_goal = pv;
                if (m_cur != m_goal) begin
                    if (c_smooth) begin
                        load_speed('0);
                        m_cruise = 1'b0;
                        m_ramp   = '0;
                    end else begin
                        load_speed((c_req < c_lim) ? c_req : c_lim);
                    end
                    m_start = m_cur;
                    m_busy  = 1'b1;
                end
            end
            FUNC_STOP: begin
                r.rel_coils = !c_hold;
                halt_motion();
            end
            default: m_cur = pv;
        endcase
        r.moving = m_busy;
        r.pos    = m_cur;
        r.spd    = m_speed;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------

    // Drive one beat, hold it until accepted, then record its expected result.
    task automatic send_item(t_func f, logic [POS_W-1:0] pv);
        int gap;
        i_valid          <= 1'b1;
        i_func           <= f;
        i_position_value <= pv;
        do @(posedge i_clk); while (o_stall);
        pending_beats.push_back(predict_motion(f, pv));
        gap = 0;
        if (gaps_on) begin
            if ($urandom_range(0, 9) == 0)
                gap = $urandom_range(8, 40);
            else if ($urandom_range(0, 2) == 0)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_ticks(int n);
        repeat (n) send_item(FUNC_TICK, $urandom());
    endtask

    // Tick until the predicted move ends, with a cap.
    task automatic tick_until_halt(int cap);
        int n;
        n = 0;
        while (m_busy && n < cap) begin
            send_item(FUNC_TICK, $urandom());
            n++;
        end
    endtask

    // Wait for every expected beat, then let the block settle.
    task automatic drain_results();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_beats.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write one register, then drop the write enable before returning.
    task automatic write_reg(logic [CFGI_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        case (idx)
            CFG_SMOOTH:  c_smooth = val[0];
            CFG_ACCEL:   c_accel  = val;
            CFG_REQ_SPD: c_req    = val;
            CFG_SPD_LIM: c_lim    = val;
            CFG_REVERSE: c_rev    = val[0];
            CFG_HOLD:    c_hold   = val[0];
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic write_all(logic sm, logic [15:0] acc, logic [15:0] req,
                             logic [15:0] lim, logic rev, logic hold);
        write_reg(CFG_SMOOTH, {15'b0, sm});
        write_reg(CFG_ACCEL, acc);
        write_reg(CFG_REQ_SPD, req);
        write_reg(CFG_SPD_LIM, lim);
        write_reg(CFG_REVERSE, {15'b0, rev});
        write_reg(CFG_HOLD, {15'b0, hold});
    endtask

    // ---------------------------------------------------------------
    // Receiver side: random stall, checker, watchdog
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
            i_stall <= 1'b1;
        end else if (stall_on && $urandom_range(0, 99) < 20) begin
            i_stall <= 1'b1;
            rx_hold <= ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : 0;
        end else begin
            i_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        t_motion_beat e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_beats.size() == 0) begin
                $error("result beat with nothing expected");
                failed = 1'b1;
            end else begin
                e = pending_beats.pop_front();
                if (o_step_pulse !== e.pulse) begin
                    $error("step_pulse: expected %0b, got %0b", e.pulse, o_step_pulse);
                    failed = 1'b1;
                end
                if (o_dir_forward !== e.fwd) begin
                    $error("dir_forward: expected %0b, got %0b", e.fwd, o_dir_forward);
                    failed = 1'b1;
                end
                if (o_moving !== e.moving) begin
                    $error("moving: expected %0b, got %0b", e.moving, o_moving);
                    failed = 1'b1;
                end
                if (o_release_coils !== e.rel_coils) begin
                    $error("release_coils: expected %0b, got %0b",
                           e.rel_coils, o_release_coils);
                    failed = 1'b1;
                end
                if (o_position_now !== e.pos) begin
                    $error("position_now: expected %0d, got %0d",
                           $signed(e.pos), o_position_now);
                    failed = 1'b1;
                end
                if (o_speed_now !== e.spd) begin
                    $error("speed_now: expected %0d, got %0d", e.spd, o_speed_now);
                    failed = 1'b1;
                end
            end
        end
    end

    // Count cycles without any accepted beat; give up when stuck.
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------

    // Commands at the position extremes, stop with and without hold,
    // go-to the current position, stop while idle, set position mid-move.
    task automatic test_commands();
        write_all(1'b0, 16'd1, 16'hFFFF, 16'hFFFF, 1'b0, 1'b0);
        send_item(FUNC_STOP, 32'h0);
        send_item(FUNC_SETPOS, 32'h7FFF_FFFF);
        send_item(FUNC_GOTO, 32'h8000_0000);
        send_ticks(40);
        send_item(FUNC_STOP, 32'hFFFF_FFFF);
        send_item(FUNC_SETPOS, 32'h8000_0000);
        send_item(FUNC_GOTO, 32'h8000_0000);
        send_item(FUNC_GOTO, 32'h7FFF_FFFF);
        send_ticks(20);
        send_item(FUNC_SETPOS, 32'h0000_0005);
        send_ticks(20);
        drain_results();
        write_reg(CFG_HOLD, 16'd1);
        send_item(FUNC_STOP, 32'h5555_AAAA);
        drain_results();
    endtask

    // Zero target speed in per-step mode and zero acceleration in smooth
    // mode: the move stays busy without steps until stopped.
    task automatic test_zero_speed();
        write_all(1'b0, 16'd0, 16'd0, 16'hFFFF, 1'b0, 1'b0);
        send_item(FUNC_GOTO, m_cur + 32'd3);
        send_ticks(30);
        send_item(FUNC_STOP, 32'h0);
        drain_results();
        write_reg(CFG_SMOOTH, 16'd1);
        send_item(FUNC_GOTO, m_cur - 32'd3);
        send_ticks(30);
        send_item(FUNC_STOP, 32'h0);
        drain_results();
    endtask

    // Per-step moves with the speed limit clamping and reversed direction.
    task automatic test_per_step();
        write_all(1'b0, 16'hFFFF, 16'hFFFF, 16'd20000, 1'b0, 1'b0);
        send_item(FUNC_GOTO, m_cur + 32'd4);
        tick_until_halt(2000);
        drain_results();
        write_all(1'b0, 16'd7, 16'd30000, 16'd0, 1'b1, 1'b1);
        write_reg(CFG_SPD_LIM, 16'hFFFF);
        send_item(FUNC_GOTO, m_cur - 32'd4);
        tick_until_halt(2000);
        drain_results();
    endtask

    // Smooth go-to: the move starts from zero speed and waits for the next
    // acceleration period; stop it before then.
    task automatic test_smooth_ramp();
        write_all(1'b1, 16'd6000, 16'hFFFF, 16'd9000, 1'b0, 1'b0);
        send_item(FUNC_GOTO, m_cur + 32'd400);
        send_ticks(100);
        send_item(FUNC_STOP, 32'h0);
        drain_results();
    endtask

    function automatic logic [15:0] pick_speed();
        case ($urandom_range(0, 9))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 9999));
            default: return 16'($urandom_range(10000, 65535));
        endcase
    endfunction

    // Random phases with fresh settings; mostly ticks around near moves.
    task automatic test_random();
        int k, sel;
        logic [15:0] acc;
        for (int ph = 0; ph < 12; ph++) begin
            case ($urandom_range(0, 3))
                0:       acc = 16'hFFFF;
                1:       acc = 16'd0;
                default: acc = 16'($urandom());
            endcase
            write_all(($urandom_range(0, 5) == 0), acc, pick_speed(), pick_speed(),
                      1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            for (k = 0; k < 100; k++) begin
                sel = $urandom_range(0, 99);
                if (sel < 82)
                    send_item(FUNC_TICK, $urandom());
                else if (sel < 90)
                    send_item(FUNC_GOTO, m_cur + 32'($signed($urandom_range(0, 40)) - 20));
                else if (sel < 93)
                    send_item(FUNC_GOTO, $urandom());
                else if (sel < 96)
                    send_item(FUNC_STOP, $urandom());
                else if (sel < 98)
                    send_item(FUNC_SETPOS, $urandom());
                else
                    send_item(FUNC_SETPOS, m_cur + 32'($urandom_range(0, 8)) - 32'd4);
            end
            drain_results();
        end
    endtask

    initial begin
        i_clk            = 1'b0;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_idx        = '0;
        i_cfg_data       = '0;
        i_valid          = 1'b0;
        i_func           = FUNC_TICK;
        i_position_value = '0;
        i_stall          = 1'b0;
        rx_hold          = 0;
        idle_cycles      = 0;
        failed           = 1'b0;
        gaps_on          = 1'b1;
        stall_on         = 1'b1;
        // reset values of the shadow registers and state
        c_smooth = 1'b0; c_accel = 16'd1; c_req = '0; c_lim = 16'hFFFF;
        c_rev = 1'b0; c_hold = 1'b0;
        m_cur = '0; m_goal = '0; m_start = '0; m_ramp = '0;
        m_step_el = '0; m_acc_el = '0; m_cruise = 1'b0; m_busy = 1'b0;
        load_speed('0);

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        test_commands();
        test_zero_speed();
        test_per_step();
        test_smooth_ramp();
        test_random();

        drain_results();
        if (!failed && pending_beats.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
